@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine: shared widths, operation and
// status codes, controller states and the command word broadcast to the cells.
// No dependencies.
package ple_pkg;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // The read tree combines eight children per node.
  localparam int FANIN     = 8;
  localparam int FANIN_LOG = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_WRITE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write;
    logic read;
    logic capture;
  } cell_cmd_t;

endpackage

@@ rtl/core/ple_channels.sv @@
// Handshake channels of the positional list engine: the request channel
// and the result channel. Depends on ple_pkg for the field widths.
interface ple_req_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink (input valid, input func, input position, input item_value,
                output ready);
endinterface

interface ple_rsp_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_value;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

@@ rtl/core/ple_cell.sv @@
// One cell of the entry chain: holds a single list entry and takes its
// neighbor's value on insert or remove. Depends on ple_pkg.
module ple_cell #(
  parameter int POS_W = 7,
  parameter int INDEX = 0
) (
  input  logic                           clk,
  input  ple_pkg::cell_cmd_t             cmd,
  input  logic [POS_W-1:0]               pos,
  input  logic [ple_pkg::DATA_W-1:0]     new_val,
  input  logic [ple_pkg::DATA_W-1:0]     left_val,
  input  logic [ple_pkg::DATA_W-1:0]     right_val,
  output logic [ple_pkg::DATA_W-1:0]     entry,
  output logic [ple_pkg::DATA_W-1:0]     grab
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] MyIndex = POS_W'(INDEX);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic [DATA_W-1:0] grab_r;
  logic [DATA_W-1:0] grab_nxt;
  logic              hit;
  logic              above;

  assign hit   = (pos == MyIndex);
  assign above = (MyIndex > pos);

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.shift_up) begin
      if (hit) begin
        entry_nxt = new_val;
      end else if (above) begin
        entry_nxt = left_val;
      end
    end else if (cmd.shift_down) begin
      if (hit || above) begin
        entry_nxt = right_val;
      end
    end else if (cmd.write && hit) begin
      entry_nxt = new_val;
    end else begin
      entry_nxt = entry_r;
    end
  end

  // Only the addressed cell puts its value on the read tree.
  always_comb begin
    grab_nxt = grab_r;
    if (cmd.capture) begin
      grab_nxt = (cmd.read && hit) ? entry_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    grab_r  <= grab_nxt;
  end

  assign entry = entry_r;
  assign grab  = grab_r;

endmodule

@@ rtl/core/ple_or_tree.sv @@
// Registered OR tree that brings the one selected cell value to a single
// output, eight children per node and a register at each level. Depends on ple_pkg.
module ple_or_tree #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic [ple_pkg::DATA_W-1:0] leaf [CAPACITY],
  output logic [ple_pkg::DATA_W-1:0] root
);
  import ple_pkg::*;

  localparam int IdxW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int Levels = (IdxW + FANIN_LOG - 1) / FANIN_LOG;

  wire [DATA_W-1:0] tier [Levels+1][CAPACITY];

  genvar k, n, j;
  generate
    for (n = 0; n < CAPACITY; n++) begin : g_leaf
      assign tier[0][n] = leaf[n];
    end

    for (k = 1; k <= Levels; k++) begin : g_lvl
      localparam int PrevN = (CAPACITY + (1 << (FANIN_LOG * (k - 1))) - 1)
                             >> (FANIN_LOG * (k - 1));
      localparam int CurN  = (CAPACITY + (1 << (FANIN_LOG * k)) - 1) >> (FANIN_LOG * k);
      for (n = 0; n < CurN; n++) begin : g_node
        logic [DATA_W-1:0] kid [FANIN];
        logic [DATA_W-1:0] node_nxt;
        logic [DATA_W-1:0] node_r;

        for (j = 0; j < FANIN; j++) begin : g_kid
          if (FANIN * n + j < PrevN) begin : g_used
            assign kid[j] = tier[k-1][FANIN*n+j];
          end else begin : g_pad
            assign kid[j] = '0;
          end
        end

        always_comb begin
          node_nxt = '0;
          for (int c = 0; c < FANIN; c++) begin
            node_nxt = node_nxt | kid[c];
          end
        end

        always_ff @(posedge clk) begin
          node_r <= node_nxt;
        end

        assign tier[k][n] = node_r;
      end
    end
  endgenerate

  assign root = tier[Levels][0];

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Positional list engine: an ordered list of signed 32-bit entries kept in
// a chain of cells. Depends on ple_pkg, ple_channels, ple_cell, ple_or_tree.
//
// Usage:
//   in_req carries one request (func, position, item_value) per valid/ready
//   handshake: insert at a position from 0 to the count, remove, read or
//   overwrite an entry below the count. out_rsp returns exactly one result
//   per request: status, read_value (the entry on a successful read, else
//   zero) and entry_count after the request.
//   Every cell shifts in the same cycle, so inserts and removes cost no more
//   than reads. The read path is a registered OR tree of L = ceil(log8
//   CAPACITY) levels (2 at 64 entries), and every request runs through it.
//   One request is in work at a time: the next is accepted only after the
//   result of the last has been loaded into the output register.
//   A result waits in an output register; the next request is accepted while
//   it waits, and its result holds back until the receiver takes the first.
//   Reset (rst_n low, synchronous) empties the list and drops any request or
//   result in flight. Entry contents are not cleared; only entries below the
//   count are ever visible.
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ple_req_if.sink    in_req,
  ple_rsp_if.source  out_rsp
);
  import ple_pkg::*;

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int CmpW   = (CntW > POS_W) ? CntW : POS_W;
  localparam int IdxW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int Levels = (IdxW + FANIN_LOG - 1) / FANIN_LOG;
  localparam int WaitW  = (Levels > 1) ? $clog2(Levels) : 1;

  state_t            state_r;
  state_t            state_nxt;
  logic [WaitW-1:0]  wait_r;
  logic [WaitW-1:0]  wait_nxt;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   count_nxt;

  func_t             func_r;
  logic [CmpW-1:0]   pos_r;
  logic [DATA_W-1:0] val_r;
  status_t           stat_r;
  status_t           stat_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  status_t             out_status_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic              accept;
  logic              load_out;
  logic [CmpW-1:0]   count_ext;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] root;
  logic [DATA_W-1:0] ent  [CAPACITY];
  logic [DATA_W-1:0] grab [CAPACITY];

  assign accept    = in_req.valid && in_req.ready;
  assign count_ext = CmpW'(count_r);

  // Status check for the request held in the execute state.
  always_comb begin
    stat_nxt = ST_OK;
    if (func_r == FUNC_INSERT) begin
      if (pos_r > count_ext) begin
        stat_nxt = ST_RANGE;
      end else if (count_ext == CmpW'(CAPACITY)) begin
        stat_nxt = ST_FULL;
      end
    end else if (pos_r >= count_ext) begin
      stat_nxt = ST_RANGE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_WAIT;
      S_WAIT: if (wait_r == '0) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_rsp.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_req.ready = 1'b0;
    cmd          = '0;
    load_out     = 1'b0;
    wait_nxt     = wait_r;
    count_nxt    = count_r;
    unique case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
      end
      S_EXEC: begin
        cmd.capture = 1'b1;
        wait_nxt    = WaitW'(Levels - 1);
        if (stat_nxt == ST_OK) begin
          unique case (func_r)
            FUNC_INSERT: begin
              cmd.shift_up = 1'b1;
              count_nxt    = count_r + CntW'(1);
            end
            FUNC_REMOVE: begin
              cmd.shift_down = 1'b1;
              count_nxt      = count_r - CntW'(1);
            end
            FUNC_READ:  cmd.read  = 1'b1;
            FUNC_WRITE: cmd.write = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      S_WAIT: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - WaitW'(1);
        end
      end
      S_DONE: begin
        load_out = !out_valid_r || out_rsp.ready;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_req.func);
      pos_r  <= CmpW'(in_req.position);
      val_r  <= in_req.item_value;
    end
    if (state_r == S_EXEC) begin
      stat_r <= stat_nxt;
    end
    if (load_out) begin
      out_status_r <= stat_r;
      out_value_r  <= root;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_val;
      logic [DATA_W-1:0] right_val;

      if (i == 0) begin : g_first
        assign left_val = '0;
      end else begin : g_mid_l
        assign left_val = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_val = '0;
      end else begin : g_mid_r
        assign right_val = ent[i+1];
      end

      ple_cell #(
        .POS_W (CmpW),
        .INDEX (i)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .pos       (pos_r),
        .new_val   (val_r),
        .left_val  (left_val),
        .right_val (right_val),
        .entry     (ent[i]),
        .grab      (grab[i])
      );
    end
  endgenerate

  ple_or_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (grab),
    .root (root)
  );

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.entry_count = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + CntW'(1) ||
                      count_r == $past(count_r) - CntW'(1)))
    else $error("list count moved by more than one");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) != S_EXEC) |-> $stable(count_r))
    else $error("list count changed outside execute state");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_value_r == '0)
    else $error("failed request returned nonzero read data");
`endif

endmodule
